>>> hw/rtl/sacf_pkg.sv
// ----------------------------------------------------------------------------
// sacf_pkg: shared types and constants for the set-associative lookup core
// Field widths, register indexes, reset values and the result beat layout.
// ----------------------------------------------------------------------------
package sacf_pkg;

  localparam int VAL_W  = 16;  // data_value / tag width
  localparam int CFG_W  = 9;   // widest config register
  localparam int WCFG_W = 4;   // way_count register width
  localparam int CNT_W  = 32;  // statistics counters
  localparam int IDX_W  = 1;   // config register index

  localparam logic [IDX_W-1:0] REG_SET_COUNT = 1'b0;
  localparam logic [IDX_W-1:0] REG_WAY_COUNT = 1'b1;

  localparam logic [CFG_W-1:0]  SET_COUNT_RST = 9'd1;
  localparam logic [WCFG_W-1:0] WAY_COUNT_RST = 4'd4;

  localparam int DEF_MAX_SETS    = 256;
  localparam int DEF_MAX_WAYS    = 8;
  localparam int QUEUE_DEPTH     = 2;
  localparam int DIGITS_PER_STEP = 4;  // remainder bits retired per cycle

  typedef struct packed {
    logic             is_hit;
    logic [2:0]       way_used;
    logic             did_replace;
    logic [VAL_W-1:0] evicted_value;
    logic [7:0]       set_used;
    logic [CNT_W-1:0] input_total;
    logic [CNT_W-1:0] hit_total;
    logic [CNT_W-1:0] miss_total;
    logic [CNT_W-1:0] replace_total;
  } result_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    return (&c) ? c : c + CNT_W'(1);
  endfunction

endpackage

>>> hw/rtl/sacf_queue.sv
// ----------------------------------------------------------------------------
// sacf_queue: small FIFO between classifier and lookup engine
// Holds value and set index of classified items until the back end pops them.
// ----------------------------------------------------------------------------
module sacf_queue #(
  parameter int DW    = 24,
  parameter int DEPTH = sacf_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  logic [DW-1:0] push_data,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output logic [DW-1:0] head
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [DW-1:0] slot [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (32'(wr_ptr) == DEPTH - 1) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (32'(rd_ptr) == DEPTH - 1) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

>>> hw/rtl/sacf_front.sv
// ----------------------------------------------------------------------------
// sacf_front: input classifier
// Accepts a value and computes its set index (value mod set count) with a
// restoring remainder unit, several bits per cycle, then queues the item.
// ----------------------------------------------------------------------------
module sacf_front #(
  parameter int SCNT_W = 9,
  parameter int SET_W  = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [sacf_pkg::VAL_W-1:0]  in_value,
  input  logic [SCNT_W-1:0]           sets,
  input  logic                        hold,
  output logic                        q_push,
  output logic [sacf_pkg::VAL_W+SET_W-1:0] q_data,
  input  logic                        q_full
);
  import sacf_pkg::*;

  localparam int NSTEP   = VAL_W / DIGITS_PER_STEP;
  localparam int STEP_CW = (NSTEP > 1) ? $clog2(NSTEP) : 1;

  typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} fstate_t;

  fstate_t             st;
  logic [VAL_W-1:0]    val;
  logic [VAL_W-1:0]    shv;
  logic [SCNT_W-1:0]   rem;
  logic [SCNT_W-1:0]   div;
  logic [STEP_CW-1:0]  step;
  logic [SCNT_W-1:0]   rem_next;
  logic [SCNT_W:0]     trial;
  logic [SCNT_W-1:0]   set_src;
  logic                last_step;

  assign in_stall  = (st != F_IDLE) || hold;
  assign last_step = (step == STEP_CW'(NSTEP - 1));

  // one restoring step per bit; rem < div keeps trial below 2*div
  always_comb begin
    rem_next = rem;
    trial    = '0;
    for (int i = 0; i < DIGITS_PER_STEP; i++) begin
      trial = {rem_next, shv[VAL_W-1-i]};
      if (trial >= {1'b0, div}) begin
        trial = trial - {1'b0, div};
      end
      rem_next = trial[SCNT_W-1:0];
    end
  end

  assign set_src = (st == F_DIV) ? rem_next : rem;
  assign q_data  = {val, set_src[SET_W-1:0]};
  assign q_push  = ((st == F_DIV) && last_step && !q_full) ||
                   ((st == F_PUSH) && !q_full);

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= F_IDLE;
    end else begin
      case (st)
        F_IDLE: begin
          if (in_valid && !in_stall) begin
            val  <= in_value;
            shv  <= in_value;
            rem  <= '0;
            div  <= sets;
            step <= '0;
            st   <= F_DIV;
          end
        end
        F_DIV: begin
          rem  <= rem_next;
          shv  <= shv << DIGITS_PER_STEP;
          step <= step + STEP_CW'(1);
          if (last_step) begin
            st <= q_full ? F_PUSH : F_IDLE;
          end
        end
        F_PUSH: begin
          if (!q_full) begin
            st <= F_IDLE;
          end
        end
        default: st <= F_IDLE;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) q_push |-> !q_full)
    else $error("push into full queue");

endmodule

>>> hw/rtl/sacf_back.sv
// ----------------------------------------------------------------------------
// sacf_back: lookup and update engine
// Reads one set row (tags, valid bits, victim pointer), resolves hit, fill or
// replacement, writes the row back on a miss and registers the result beat.
// ----------------------------------------------------------------------------
module sacf_back #(
  parameter int MAX_SETS = sacf_pkg::DEF_MAX_SETS,
  parameter int MAX_WAYS = sacf_pkg::DEF_MAX_WAYS,
  parameter int SET_W    = 8,
  parameter int WAY_W    = 3,
  parameter int WCNT_W   = 4
) (
  input  logic                             clk,
  input  logic                             rst,
  output logic                             clearing,
  input  logic                             q_valid,
  output logic                             q_pop,
  input  logic [sacf_pkg::VAL_W+SET_W-1:0] q_data,
  input  logic [WCNT_W-1:0]                ways,
  output sacf_pkg::result_t                res,
  output logic                             res_valid,
  input  logic                             res_stall
);
  import sacf_pkg::*;

  localparam int VLD_LO = MAX_WAYS * VAL_W;
  localparam int PTR_LO = VLD_LO + MAX_WAYS;
  localparam int ROW_W  = PTR_LO + WAY_W;

  typedef enum logic [1:0] {B_CLEAR, B_IDLE, B_LOOK} bstate_t;

  bstate_t           st;
  logic [ROW_W-1:0]  row_mem [MAX_SETS];
  logic [ROW_W-1:0]  rd_row;
  logic [ROW_W-1:0]  new_row;
  logic [ROW_W-1:0]  mem_wd;
  logic [SET_W-1:0]  mem_wa;
  logic              mem_we;
  logic [SET_W-1:0]  clr_idx;
  logic [VAL_W-1:0]  cur_val;
  logic [SET_W-1:0]  cur_set;
  logic [CNT_W-1:0]  in_cnt;
  logic [CNT_W-1:0]  hit_cnt;
  logic [CNT_W-1:0]  miss_cnt;
  logic [CNT_W-1:0]  rep_cnt;

  logic [MAX_WAYS-1:0] row_vld;
  logic [WAY_W-1:0]    row_ptr;
  logic                hit;
  logic                have_empty;
  logic                replace;
  logic [WAY_W-1:0]    hit_way;
  logic [WAY_W-1:0]    emp_way;
  logic [WAY_W-1:0]    vic;
  logic [WAY_W-1:0]    way;
  logic [WAY_W-1:0]    ptr_new;
  logic [VAL_W-1:0]    evicted;
  logic [31:0]         way_ext;
  logic [31:0]         set_ext;
  logic                fire;

  assign clearing = (st == B_CLEAR);
  assign q_pop    = (st == B_IDLE) && q_valid;
  assign fire     = (st == B_LOOK) && (!res_valid || !res_stall);

  assign row_vld = rd_row[VLD_LO +: MAX_WAYS];
  assign row_ptr = rd_row[PTR_LO +: WAY_W];

  // way search; descending scan leaves the lowest match
  always_comb begin
    hit        = 1'b0;
    hit_way    = '0;
    have_empty = 1'b0;
    emp_way    = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (32'(w) < 32'(ways)) begin
        if (row_vld[w]) begin
          if (rd_row[w*VAL_W +: VAL_W] == cur_val) begin
            hit     = 1'b1;
            hit_way = WAY_W'(w);
          end
        end else begin
          have_empty = 1'b1;
          emp_way    = WAY_W'(w);
        end
      end
    end
  end

  always_comb begin
    // stale pointer (ways reduced) falls back to way 0
    vic     = (32'(row_ptr) < 32'(ways)) ? row_ptr : '0;
    replace = !hit && !have_empty;
    way     = hit ? hit_way : (have_empty ? emp_way : vic);
    evicted = replace ? rd_row[way*VAL_W +: VAL_W] : '0;
    ptr_new = row_ptr;
    if (replace) begin
      ptr_new = ((32'(vic) + 32'd1) >= 32'(ways)) ? '0 : vic + WAY_W'(1);
    end
    new_row                        = rd_row;
    new_row[way*VAL_W +: VAL_W]    = cur_val;
    new_row[VLD_LO + way]          = 1'b1;
    new_row[PTR_LO +: WAY_W]       = ptr_new;
    way_ext                        = 32'(way);
    set_ext                        = 32'(cur_set);
  end

  assign mem_we = clearing || (fire && !hit);
  assign mem_wa = clearing ? clr_idx : cur_set;
  assign mem_wd = clearing ? '0 : new_row;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      row_mem[mem_wa] <= mem_wd;
    end
    if (q_pop) begin
      rd_row <= row_mem[q_data[SET_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= B_CLEAR;
      clr_idx   <= '0;
      res_valid <= 1'b0;
      in_cnt    <= '0;
      hit_cnt   <= '0;
      miss_cnt  <= '0;
      rep_cnt   <= '0;
    end else begin
      case (st)
        B_CLEAR: begin
          clr_idx <= clr_idx + SET_W'(1);
          if (32'(clr_idx) == 32'(MAX_SETS - 1)) begin
            st <= B_IDLE;
          end
        end
        B_IDLE: begin
          if (q_valid) begin
            cur_val <= q_data[VAL_W+SET_W-1 -: VAL_W];
            cur_set <= q_data[SET_W-1:0];
            st      <= B_LOOK;
          end
        end
        B_LOOK: begin
          if (fire) begin
            st <= B_IDLE;
          end
        end
        default: st <= B_IDLE;
      endcase

      if (fire) begin
        in_cnt   <= sat_inc(in_cnt);
        hit_cnt  <= hit ? sat_inc(hit_cnt) : hit_cnt;
        miss_cnt <= hit ? miss_cnt : sat_inc(miss_cnt);
        rep_cnt  <= replace ? sat_inc(rep_cnt) : rep_cnt;
        res_valid             <= 1'b1;
        res.is_hit            <= hit;
        res.way_used          <= way_ext[2:0];
        res.did_replace       <= replace;
        res.evicted_value     <= evicted;
        res.set_used          <= set_ext[7:0];
        res.input_total       <= sat_inc(in_cnt);
        res.hit_total         <= hit ? sat_inc(hit_cnt) : hit_cnt;
        res.miss_total        <= hit ? miss_cnt : sat_inc(miss_cnt);
        res.replace_total     <= replace ? sat_inc(rep_cnt) : rep_cnt;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  a_evict_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.did_replace |-> res.evicted_value == '0)
    else $error("evicted value without replacement");

  a_hit_excl: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(res.is_hit && res.did_replace))
    else $error("hit and replace on same beat");

  a_hit_count: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.is_hit |-> res.hit_total != '0)
    else $error("hit reported with zero hit count");

endmodule

>>> hw/rtl/set_assoc_cache_fifo_lookup_core.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_fifo_lookup_core: set-associative lookup, FIFO replacement
// Each value is its own tag; set = value mod set_count. Hit, fill of the
// lowest empty way, or round-robin replacement, with saturating statistics.
// ----------------------------------------------------------------------------
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+------------------------------------------
//  input   | in_valid  | in_stall  | data_value
//  result  | out_valid | out_stall | is_hit, way_used, did_replace,
//          |           |           | evicted_value, set_used, *_total
//  config  | cfg_wr    | (none)    | cfg_index, cfg_data
//
//  - Front end takes no new item while its remainder unit works through the
//    VAL_W bits of the last one (4 bits a cycle) or waits to queue it.
//  - Back end reads the set row, then resolves, writes back on a miss and
//    registers the result; with out_stall low, the front end sets the rate.
//  - After reset a clearing pass writes every set row; in_stall is high
//    meanwhile. Config writes are taken at any time.
//  - A two-entry queue parts front and back; out_stall backs up through the
//    result register and queue before in_stall rises.
//
module set_assoc_cache_fifo_lookup_core #(
  parameter int MAX_SETS = sacf_pkg::DEF_MAX_SETS,
  parameter int MAX_WAYS = sacf_pkg::DEF_MAX_WAYS
) (
  input  logic                        clk,
  input  logic                        rst,
  // config write port
  input  logic                        cfg_wr,
  input  logic [sacf_pkg::IDX_W-1:0]  cfg_index,
  input  logic [sacf_pkg::CFG_W-1:0]  cfg_data,
  // input beats
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [sacf_pkg::VAL_W-1:0]  data_value,
  // result beats
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        is_hit,
  output logic [2:0]                  way_used,
  output logic                        did_replace,
  output logic [sacf_pkg::VAL_W-1:0]  evicted_value,
  output logic [7:0]                  set_used,
  output logic [sacf_pkg::CNT_W-1:0]  input_total,
  output logic [sacf_pkg::CNT_W-1:0]  hit_total,
  output logic [sacf_pkg::CNT_W-1:0]  miss_total,
  output logic [sacf_pkg::CNT_W-1:0]  replace_total
);
  import sacf_pkg::*;

  localparam int SCNT_W = $clog2(MAX_SETS + 1);
  localparam int SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WCNT_W = $clog2(MAX_WAYS + 1);
  localparam int QDW    = VAL_W + SET_W;

  logic [CFG_W-1:0]  set_count;
  logic [WCFG_W-1:0] way_count;
  logic [31:0]       sc_clamp;
  logic [31:0]       wc_clamp;
  logic [SCNT_W-1:0] sets_eff;
  logic [WCNT_W-1:0] ways_eff;

  logic              q_push;
  logic [QDW-1:0]    q_wdata;
  logic              q_full;
  logic              q_pop;
  logic              q_valid;
  logic [QDW-1:0]    q_head;
  logic              clearing;
  result_t           res;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      set_count <= SET_COUNT_RST;
      way_count <= WAY_COUNT_RST;
    end else if (cfg_wr) begin
      case (cfg_index)
        REG_SET_COUNT: set_count <= cfg_data;
        REG_WAY_COUNT: way_count <= cfg_data[WCFG_W-1:0];
        default: ;
      endcase
    end
  end

  // out-of-range counts clamp to 1..MAX
  always_comb begin
    sc_clamp = 32'(set_count);
    if (sc_clamp == 32'd0) begin
      sc_clamp = 32'd1;
    end else if (sc_clamp > 32'(MAX_SETS)) begin
      sc_clamp = 32'(MAX_SETS);
    end
    wc_clamp = 32'(way_count);
    if (wc_clamp == 32'd0) begin
      wc_clamp = 32'd1;
    end else if (wc_clamp > 32'(MAX_WAYS)) begin
      wc_clamp = 32'(MAX_WAYS);
    end
    sets_eff = SCNT_W'(sc_clamp);
    ways_eff = WCNT_W'(wc_clamp);
  end

  sacf_front #(
    .SCNT_W (SCNT_W),
    .SET_W  (SET_W)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_value (data_value),
    .sets     (sets_eff),
    .hold     (clearing),
    .q_push   (q_push),
    .q_data   (q_wdata),
    .q_full   (q_full)
  );

  sacf_queue #(
    .DW    (QDW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head      (q_head)
  );

  sacf_back #(
    .MAX_SETS (MAX_SETS),
    .MAX_WAYS (MAX_WAYS),
    .SET_W    (SET_W),
    .WAY_W    (WAY_W),
    .WCNT_W   (WCNT_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .clearing  (clearing),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_data    (q_head),
    .ways      (ways_eff),
    .res       (res),
    .res_valid (out_valid),
    .res_stall (out_stall)
  );

  assign is_hit        = res.is_hit;
  assign way_used      = res.way_used;
  assign did_replace   = res.did_replace;
  assign evicted_value = res.evicted_value;
  assign set_used      = res.set_used;
  assign input_total   = res.input_total;
  assign hit_total     = res.hit_total;
  assign miss_total    = res.miss_total;
  assign replace_total = res.replace_total;

endmodule
